// ===== sv/cosc_pkg.sv =====
package cosc_pkg;

    localparam int PHASE_BITS_DEF  = 32;
    localparam int NOISE_SHIFT_DEF = 4;

    localparam int INC_W     = 32;
    localparam int DUTY_W    = 8;
    localparam int SAMPLE_W  = 8;
    localparam int LEVEL_W   = 8;
    localparam int LFSR_W    = 15;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    localparam logic [LFSR_W-1:0]   LFSR_RESET = 15'h7fff;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MID = 8'd128;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 8'd255;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 8'd0;
    localparam logic [DUTY_W-1:0]   DUTY_LO    = 8'd1;
    localparam logic [DUTY_W-1:0]   DUTY_HI    = 8'd254;

    typedef enum logic [2:0] {
        WAVE_PULSE    = 3'd0,
        WAVE_TRIANGLE = 3'd1,
        WAVE_SAW      = 3'd2,
        WAVE_NOISE    = 3'd3,
        WAVE_SILENCE  = 3'd4
    } t_wave;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WAVE        = 2'd0,
        CFG_NOISE_SHORT = 2'd1,
        CFG_SUB_LEVEL   = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_CARRY,
        ST_NOISE,
        ST_MIX,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic noise_en;
    } t_phase_ctl;

    typedef struct packed {
        logic [SAMPLE_W-1:0] main_top;
        logic                sub_msb;
        logic                pulse_hi;
    } t_phase_sts;

endpackage

// ===== sv/cosc_if.sv =====
interface cosc_in_if;
    logic                           valid;
    logic                           ready;
    logic [cosc_pkg::INC_W-1:0]     phase_increment;
    logic [cosc_pkg::DUTY_W-1:0]    duty;

    modport source (output valid, output phase_increment, output duty, input ready);
    modport sink   (input valid, input phase_increment, input duty, output ready);
endinterface

interface cosc_out_if;
    logic                           valid;
    logic                           ready;
    logic [cosc_pkg::SAMPLE_W-1:0]  sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface cosc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [cosc_pkg::CFG_IDX_W-1:0] index;
    logic [cosc_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/chiptune_oscillator_lfsr_noise.sv =====
// Chiptune oscillator: one 8-bit sample item for each phase increment item.
// Channels: i_in (phase_increment, duty), o_out (sample), i_cfg (register
// writes: index 0 wave_select, 1 noise_short, 2 sub_level; always ready).
// An accepted item is added into the main and sub-octave phase accumulators
// (and, in noise mode, the noise accumulator) one bit per cycle, LSB first;
// the pulse compare runs in the same bit stream. In noise mode the LFSR then
// steps once per cycle, one step for each carry out of the noise accumulator
// (0 to 2^NOISE_RATE_SHIFT carries). With sub mixing on, a shift-add
// multiplier then scales the sample. i_in is ready only while idle, so one
// item is in work at a time and a new item is not accepted until the last
// is handed to the output register. The result sits in that register: a
// stalled receiver does not stop the next item, which waits in its last
// state until that register is free. Synchronous reset clears the phases
// and configuration, sets the LFSR to all ones and empties the output
// register.
module chiptune_oscillator_lfsr_noise #(
    parameter int PHASE_BITS       = cosc_pkg::PHASE_BITS_DEF,
    parameter int NOISE_RATE_SHIFT = cosc_pkg::NOISE_SHIFT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cosc_in_if.sink       i_in,
    cosc_out_if.source    o_out,
    cosc_cfg_if.sink      i_cfg
);
    localparam int BW = $clog2(PHASE_BITS);
    localparam logic [BW-1:0] LAST_BIT = BW'(PHASE_BITS - 1);

    cosc_pkg::t_state              r_state, n_state;
    logic [BW-1:0]                 r_bit, n_bit;
    logic [cosc_pkg::SAMPLE_W-1:0] r_smp, n_smp;
    logic                          r_out_valid, n_out_valid;
    logic [cosc_pkg::SAMPLE_W-1:0] r_out_sample, n_out_sample;

    logic [2:0]                    r_wave;
    logic                          r_short;
    logic [cosc_pkg::LEVEL_W-1:0]  r_level;

    cosc_pkg::t_phase_ctl          ctl;
    cosc_pkg::t_phase_sts          sts;
    logic [NOISE_RATE_SHIFT:0]     carries;
    logic                          lfsr_load, lfsr_busy, lfsr_bit;
    logic                          mix_start, mix_busy, mix_en, is_noise;
    logic [cosc_pkg::SAMPLE_W-1:0] mix_q, base;
    logic [4:0]                    tri_pos;
    logic [3:0]                    tri_lvl;
    logic                          in_ready;

    cosc_phase #(
        .PHASE_BITS       (PHASE_BITS),
        .NOISE_RATE_SHIFT (NOISE_RATE_SHIFT)
    ) u_phase (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_inc     (i_in.phase_increment),
        .i_duty    (i_in.duty),
        .o_sts     (sts),
        .o_carries (carries)
    );

    cosc_lfsr #(
        .NOISE_RATE_SHIFT (NOISE_RATE_SHIFT)
    ) u_lfsr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (lfsr_load),
        .i_count (carries),
        .i_short (r_short),
        .o_busy  (lfsr_busy),
        .o_bit   (lfsr_bit)
    );

    cosc_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mix_start),
        .i_smp   (base),
        .i_sq    (~sts.sub_msb),
        .i_level (r_level),
        .o_busy  (mix_busy),
        .o_q     (mix_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave  <= cosc_pkg::WAVE_PULSE;
            r_short <= 1'b0;
            r_level <= '0;
        end else if (i_cfg.valid) begin
            case (cosc_pkg::t_cfg_idx'(i_cfg.index))
                cosc_pkg::CFG_WAVE:        r_wave  <= i_cfg.data[2:0];
                cosc_pkg::CFG_NOISE_SHORT: r_short <= i_cfg.data[0];
                cosc_pkg::CFG_SUB_LEVEL:   r_level <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;

    assign is_noise = (r_wave == cosc_pkg::WAVE_NOISE);
    assign mix_en   = (r_level != '0) &&
                      (r_wave inside {[cosc_pkg::WAVE_PULSE:cosc_pkg::WAVE_NOISE]});
    assign tri_pos  = sts.main_top[7:3];
    assign tri_lvl  = tri_pos[4] ? ~tri_pos[3:0] : tri_pos[3:0];

    always_comb begin
        case (cosc_pkg::t_wave'(r_wave))
            cosc_pkg::WAVE_PULSE:
                base = sts.pulse_hi ? cosc_pkg::SAMPLE_MAX : cosc_pkg::SAMPLE_MIN;
            cosc_pkg::WAVE_TRIANGLE: base = {tri_lvl, tri_lvl};
            cosc_pkg::WAVE_SAW:      base = sts.main_top;
            cosc_pkg::WAVE_NOISE:
                base = lfsr_bit ? cosc_pkg::SAMPLE_MAX : cosc_pkg::SAMPLE_MIN;
            default:                 base = cosc_pkg::SAMPLE_MID;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cosc_pkg::ST_IDLE;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bit       <= n_bit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_smp        <= n_smp;
        r_out_sample <= n_out_sample;
    end

    always_comb begin
        n_state      = r_state;
        n_bit        = r_bit;
        n_smp        = r_smp;
        n_out_valid  = r_out_valid & ~o_out.ready;
        n_out_sample = r_out_sample;
        ctl          = '0;
        lfsr_load    = 1'b0;
        mix_start    = 1'b0;
        in_ready     = 1'b0;
        case (r_state)
            cosc_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (i_in.valid) begin
                    ctl.load = 1'b1;
                    n_bit    = '0;
                    n_state  = cosc_pkg::ST_ADD;
                end
            end
            cosc_pkg::ST_ADD: begin
                ctl.step     = 1'b1;
                ctl.noise_en = is_noise;
                n_bit        = r_bit + 1'b1;
                if (r_bit == LAST_BIT) begin
                    n_state = cosc_pkg::ST_CARRY;
                end
            end
            cosc_pkg::ST_CARRY: begin
                lfsr_load = is_noise;
                n_state   = cosc_pkg::ST_NOISE;
            end
            cosc_pkg::ST_NOISE: begin
                if (!lfsr_busy) begin
                    if (mix_en) begin
                        mix_start = 1'b1;
                        n_state   = cosc_pkg::ST_MIX;
                    end else begin
                        n_smp   = base;
                        n_state = cosc_pkg::ST_DONE;
                    end
                end
            end
            cosc_pkg::ST_MIX: begin
                if (!mix_busy) begin
                    n_smp   = mix_q;
                    n_state = cosc_pkg::ST_DONE;
                end
            end
            cosc_pkg::ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_sample = r_smp;
                    n_state      = cosc_pkg::ST_IDLE;
                end
            end
            default: n_state = cosc_pkg::ST_IDLE;
        endcase
    end

    assign i_in.ready   = in_ready;
    assign o_out.valid  = r_out_valid;
    assign o_out.sample = r_out_sample;

endmodule

// ===== sv/cosc_phase.sv =====
module cosc_phase #(
    parameter int PHASE_BITS       = cosc_pkg::PHASE_BITS_DEF,
    parameter int NOISE_RATE_SHIFT = cosc_pkg::NOISE_SHIFT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cosc_pkg::t_phase_ctl          i_ctl,
    input  logic [cosc_pkg::INC_W-1:0]    i_inc,
    input  logic [cosc_pkg::DUTY_W-1:0]   i_duty,
    output cosc_pkg::t_phase_sts          o_sts,
    output logic [NOISE_RATE_SHIFT:0]     o_carries
);
    localparam int PB = PHASE_BITS;
    localparam int CW = NOISE_RATE_SHIFT + 1;
    localparam logic [PB-1:0] PHASE_MASK = '1;
    localparam logic [PB-1:0] THRESH_STEP = PHASE_MASK / PB'(255);

    logic [PB-1:0] r_main, r_sub, r_nacc;
    logic [PB-1:0] r_inc, r_ninc, r_thr;
    logic [CW-1:0] r_nhi;
    logic          r_c_main, r_c_sub, r_c_nacc, r_lt;

    logic [PB-1:0]                inc_trunc;
    logic [cosc_pkg::DUTY_W-1:0]  duty_c;
    logic [PB-1:0]                thr_val;
    logic                         s_main, c_main, s_sub, c_sub, s_nacc, c_nacc;

    assign inc_trunc = i_inc[PB-1:0];

    always_comb begin
        if (i_duty < cosc_pkg::DUTY_LO) begin
            duty_c = cosc_pkg::DUTY_LO;
        end else if (i_duty > cosc_pkg::DUTY_HI) begin
            duty_c = cosc_pkg::DUTY_HI;
        end else begin
            duty_c = i_duty;
        end
    end

    assign thr_val = PB'(PB'(duty_c) * THRESH_STEP);

    assign s_main = r_main[0] ^ r_inc[0] ^ r_c_main;
    assign c_main = (r_main[0] & r_inc[0]) | (r_c_main & (r_main[0] ^ r_inc[0]));
    assign s_sub  = r_sub[0] ^ r_inc[1] ^ r_c_sub;
    assign c_sub  = (r_sub[0] & r_inc[1]) | (r_c_sub & (r_sub[0] ^ r_inc[1]));
    assign s_nacc = r_nacc[0] ^ r_ninc[0] ^ r_c_nacc;
    assign c_nacc = (r_nacc[0] & r_ninc[0]) | (r_c_nacc & (r_nacc[0] ^ r_ninc[0]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main   <= '0;
            r_sub    <= '0;
            r_nacc   <= '0;
            r_c_main <= 1'b0;
            r_c_sub  <= 1'b0;
            r_c_nacc <= 1'b0;
            r_lt     <= 1'b0;
        end else if (i_ctl.load) begin
            r_c_main <= 1'b0;
            r_c_sub  <= 1'b0;
            r_c_nacc <= 1'b0;
            r_lt     <= 1'b0;
        end else if (i_ctl.step) begin
            r_main   <= {s_main, r_main[PB-1:1]};
            r_c_main <= c_main;
            r_sub    <= {s_sub, r_sub[PB-1:1]};
            r_c_sub  <= c_sub;
            r_lt     <= (~s_main & r_thr[0]) | (~(s_main ^ r_thr[0]) & r_lt);
            if (i_ctl.noise_en) begin
                r_nacc   <= {s_nacc, r_nacc[PB-1:1]};
                r_c_nacc <= c_nacc;
            end else begin
                r_nacc   <= {r_nacc[0], r_nacc[PB-1:1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_inc  <= inc_trunc;
            r_ninc <= PB'(inc_trunc << NOISE_RATE_SHIFT);
            r_nhi  <= CW'(inc_trunc >> (PB - NOISE_RATE_SHIFT));
            r_thr  <= thr_val;
        end else if (i_ctl.step) begin
            r_inc  <= {1'b0, r_inc[PB-1:1]};
            r_ninc <= {1'b0, r_ninc[PB-1:1]};
            r_thr  <= {r_thr[0], r_thr[PB-1:1]};
        end
    end

    assign o_sts.main_top = r_main[PB-1 -: cosc_pkg::SAMPLE_W];
    assign o_sts.sub_msb  = r_sub[PB-1];
    assign o_sts.pulse_hi = r_lt;
    assign o_carries      = r_nhi + CW'(r_c_nacc);

endmodule

// ===== sv/cosc_lfsr.sv =====
module cosc_lfsr #(
    parameter int NOISE_RATE_SHIFT = cosc_pkg::NOISE_SHIFT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic [NOISE_RATE_SHIFT:0]     i_count,
    input  logic                          i_short,
    output logic                          o_busy,
    output logic                          o_bit
);
    logic [cosc_pkg::LFSR_W-1:0] r_lfsr;
    logic [NOISE_RATE_SHIFT:0]   r_cnt;
    logic                        fb;

    assign fb = r_lfsr[0] ^ (i_short ? r_lfsr[6] : r_lfsr[1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr <= cosc_pkg::LFSR_RESET;
            r_cnt  <= '0;
        end else if (i_load) begin
            r_cnt  <= i_count;
        end else if (o_busy) begin
            r_lfsr <= {fb, r_lfsr[cosc_pkg::LFSR_W-1:1]};
            r_cnt  <= r_cnt - 1'b1;
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_bit  = r_lfsr[0];

endmodule

// ===== sv/cosc_mix.sv =====
module cosc_mix (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [cosc_pkg::SAMPLE_W-1:0]   i_smp,
    input  logic                            i_sq,
    input  logic [cosc_pkg::LEVEL_W-1:0]    i_level,
    output logic                            o_busy,
    output logic [cosc_pkg::SAMPLE_W-1:0]   o_q
);
    localparam int PW = 2 * cosc_pkg::SAMPLE_W;
    localparam int MUL_STEPS = cosc_pkg::LEVEL_W;
    localparam int CNT_W = $clog2(MUL_STEPS + 1);

    logic [PW-1:0]                  r_acc, r_mcand;
    logic [cosc_pkg::LEVEL_W-1:0]   r_mplier;
    logic [CNT_W-1:0]               r_cnt;
    logic [PW:0]                    qsum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(MUL_STEPS);
        end else if (o_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc    <= i_sq ? ({i_level, 8'h00} - PW'(i_level)) : '0;
            r_mcand  <= PW'(i_smp);
            r_mplier <= ~i_level;
        end else if (o_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= {r_mcand[PW-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[cosc_pkg::LEVEL_W-1:1]};
        end
    end

    // divide by 255: (x + x/256 + 1) / 256 is exact over the product range
    assign qsum   = {1'b0, r_acc} + (PW+1)'(r_acc[PW-1 -: cosc_pkg::SAMPLE_W]) + (PW+1)'(1);
    assign o_q    = qsum[PW-1 -: cosc_pkg::SAMPLE_W];
    assign o_busy = (r_cnt != '0);

endmodule
